// ===== rtl/ordered_list_insert_remove_macros.svh =====
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted
`define OLIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olir: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define OLIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olir: next-cycle check failed");
`else
`define OLIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OLIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/olir_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Widths, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package olir_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_READ_OUT   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  // Read address source
  typedef enum logic [1:0] {
    RA_IDX     = 2'd0,
    RA_IDX_DEC = 2'd1,
    RA_IDX_INC = 2'd2
  } rd_addr_e;

  // Write address source
  typedef enum logic [1:0] {
    WA_IDX  = 2'd0,
    WA_FILL = 2'd1,
    WA_HEAD = 2'd2
  } wr_addr_e;

  // Write data source
  typedef enum logic [1:0] {
    WD_IN    = 2'd0,
    WD_VAL   = 2'd1,
    WD_RDATA = 2'd2
  } wr_data_e;

  typedef struct packed {
    logic     load_val;
    logic     idx_clr;
    logic     idx_load_fill;
    logic     idx_inc;
    logic     idx_dec;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_addr_e wr_addr;
    wr_data_e wr_data;
    logic     fill_inc;
    logic     fill_dec;
    logic     emit;
    logic     emit_item;
    status_e  emit_status;
  } olir_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic idx_last;
    logic idx_one;
    logic rm_last;
  } olir_stat_t;

endpackage

// ===== rtl/olir_datapath.sv =====
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory, fill and index counters, search compare and result registers.
// ----------------------------------------------------------------------------
module olir_datapath #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olir_pkg::olir_cmd_t                 cmd_i,
  output olir_pkg::olir_stat_t                stat_o,
  input  logic signed [olir_pkg::DATA_W-1:0]  value_i,
  output logic                                strobe_o,
  output logic [olir_pkg::STATUS_W-1:0]       status_o,
  output logic signed [olir_pkg::DATA_W-1:0]  item_value_o,
  output logic                                item_valid_o,
  output logic                                last_o,
  output logic [olir_pkg::COUNT_W-1:0]        entry_count_o
);
  import olir_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] wr_data;
  logic [IW-1:0]     fill_q, fill_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW:0]       idx_p1, idx_p2;
  logic [IW-1:0]     rd_idx, wr_idx;

  logic                strobe_q;
  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0]   item_value_q;
  logic                item_valid_q;
  logic                last_q;
  logic [COUNT_W-1:0]  count_q;

  assign idx_p1 = {1'b0, idx_q} + (IW+1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (IW+1)'(2);

  // Status flags toward the controller
  assign stat_o.full     = (fill_q == IW'(CAPACITY));
  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.match    = (rdata_q == val_q);
  assign stat_o.idx_last = (idx_p1 == {1'b0, fill_q});
  assign stat_o.idx_one  = (idx_q == IW'(1));
  assign stat_o.rm_last  = (idx_p2 == {1'b0, fill_q});

  // Select memory addresses and write data
  always_comb begin
    case (cmd_i.rd_addr)
      RA_IDX:     rd_idx = idx_q;
      RA_IDX_DEC: rd_idx = idx_q - IW'(1);
      RA_IDX_INC: rd_idx = idx_p1[IW-1:0];
      default:    rd_idx = idx_q;
    endcase
    case (cmd_i.wr_addr)
      WA_IDX:  wr_idx = idx_q;
      WA_FILL: wr_idx = fill_q;
      WA_HEAD: wr_idx = '0;
      default: wr_idx = idx_q;
    endcase
    case (cmd_i.wr_data)
      WD_IN:    wr_data = value_i;
      WD_VAL:   wr_data = val_q;
      WD_RDATA: wr_data = rdata_q;
      default:  wr_data = rdata_q;
    endcase
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  // Next fill and index values
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + IW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - IW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_load_fill) begin
      idx_d = fill_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1[IW-1:0];
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IW'(1);
    end
  end

  // Hold counters and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      strobe_q <= cmd_i.emit;
    end
  end

  // Capture operand and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_val) begin
      val_q <= value_i;
    end
    if (cmd_i.emit) begin
      status_q     <= cmd_i.emit_status;
      item_value_q <= cmd_i.emit_item ? rdata_q : '0;
      item_valid_q <= cmd_i.emit_item;
      last_q       <= cmd_i.emit_item ? stat_o.idx_last : 1'b1;
      count_q      <= COUNT_W'(fill_d);
    end
  end

  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign item_value_o  = item_value_q;
  assign item_valid_o  = item_valid_q;
  assign last_o        = last_q;
  assign entry_count_o = count_q;

endmodule

// ===== rtl/olir_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences push, search, gap closing and read-out over the entry memory.
// ----------------------------------------------------------------------------
module olir_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [olir_pkg::OP_W-1:0]     op_i,
  input  olir_pkg::olir_stat_t          stat_i,
  output olir_pkg::olir_cmd_t           cmd_o,
  output logic                          busy_o
);
  import olir_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_PF_RD  = 11'b000_0000_0010,
    S_PF_WR  = 11'b000_0000_0100,
    S_PF_INS = 11'b000_0000_1000,
    S_SR_RD  = 11'b000_0001_0000,
    S_SR_CMP = 11'b000_0010_0000,
    S_RM_RD  = 11'b000_0100_0000,
    S_RM_WR  = 11'b000_1000_0000,
    S_RO_RD  = 11'b001_0000_0000,
    S_RO_OUT = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Decode state into datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_val = 1'b1;
          case (op_e'(op_i))
            OP_PUSH_FRONT: begin
              if (stat_i.full) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STATUS_FULL;
              end else if (stat_i.empty) begin
                state_d = S_PF_INS;
              end else begin
                cmd_o.idx_load_fill = 1'b1;
                state_d             = S_PF_RD;
              end
            end
            OP_PUSH_BACK: begin
              cmd_o.emit = 1'b1;
              if (stat_i.full) begin
                cmd_o.emit_status = STATUS_FULL;
              end else begin
                cmd_o.wr_en       = 1'b1;
                cmd_o.wr_addr     = WA_FILL;
                cmd_o.wr_data     = WD_IN;
                cmd_o.fill_inc    = 1'b1;
                cmd_o.emit_status = STATUS_OK;
              end
            end
            OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STATUS_EMPTY;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_SR_RD;
              end
            end
            OP_READ_OUT: begin
              if (stat_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STATUS_EMPTY;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_RO_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // Shift entries back by one, last first
      S_PF_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX_DEC;
        state_d       = S_PF_WR;
      end
      S_PF_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RDATA;
        cmd_o.idx_dec = 1'b1;
        state_d       = stat_i.idx_one ? S_PF_INS : S_PF_RD;
      end
      S_PF_INS: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_addr     = WA_HEAD;
        cmd_o.wr_data     = WD_VAL;
        cmd_o.fill_inc    = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = STATUS_OK;
        state_d           = S_IDLE;
      end
      // Scan front to back for the first match
      S_SR_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX;
        state_d       = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat_i.match) begin
          if (stat_i.idx_last) begin
            cmd_o.fill_dec    = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STATUS_OK;
            state_d           = S_IDLE;
          end else begin
            state_d = S_RM_RD;
          end
        end else if (stat_i.idx_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STATUS_NOTFOUND;
          state_d           = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SR_RD;
        end
      end
      // Close the gap: move each later entry one place forward
      S_RM_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX_INC;
        state_d       = S_RM_WR;
      end
      S_RM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RDATA;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.rm_last) begin
          cmd_o.fill_dec    = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STATUS_OK;
          state_d           = S_IDLE;
        end else begin
          state_d = S_RM_RD;
        end
      end
      // Stream every entry out, front first
      S_RO_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX;
        state_d       = S_RO_OUT;
      end
      S_RO_OUT: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_item   = 1'b1;
        cmd_o.emit_status = STATUS_OK;
        cmd_o.idx_inc     = 1'b1;
        state_d           = stat_i.idx_last ? S_IDLE : S_RO_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/ordered_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Ordered list with insert and remove
// Bounded ordered list of signed 32-bit words with push, remove and read-out.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (op_i, value_i) is taken at a rising edge where start is
//   high and busy is low. Results leave on status_o, item_value_o,
//   item_valid_o, last_o and entry_count_o, each valid for the single cycle
//   strobe_o is high; last_o marks the final result of a command.
//   What each command does between acceptance and its final result strobe:
//     push back, or any command refused as full or empty: a single result word
//     push front: every entry moves back one place, then the head is written
//     remove:     entries are scanned front to back for the first match, then
//                 each later entry moves forward one place
//     read-out:   one result word per entry, front first
//   The entry memory has a single write port and a registered read, so
//   each move or compare is a read followed by a use of the read data.
//   A new command may be given in the cycle its predecessor's last result
//   is shown. Reset empties the list at once; no clearing pass is needed.
//   Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_remove_macros.svh"

module ordered_list_insert_remove #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [olir_pkg::OP_W-1:0]           op_i,
  input  logic signed [olir_pkg::DATA_W-1:0]  value_i,
  output logic                                strobe_o,
  output logic [olir_pkg::STATUS_W-1:0]       status_o,
  output logic signed [olir_pkg::DATA_W-1:0]  item_value_o,
  output logic                                item_valid_o,
  output logic                                last_o,
  output logic [olir_pkg::COUNT_W-1:0]        entry_count_o
);
  import olir_pkg::*;

  olir_cmd_t  cmd;
  olir_stat_t stat;

  olir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  olir_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .item_valid_o (item_valid_o),
    .last_o       (last_o),
    .entry_count_o(entry_count_o)
  );

  // Push back always answers on the next cycle with a single word
  `OLIR_ASSERT_NXT(a_push_back_answers, clk_i, rst_ni, start && !busy && (op_i == OP_PUSH_BACK), strobe_o && last_o)
  // An entry word always carries ok status
  `OLIR_ASSERT_IMP(a_item_ok, clk_i, rst_ni, strobe_o && item_valid_o, status_o == STATUS_OK)
  // Only read-out produces non-final words, and the block stays busy then
  `OLIR_ASSERT_IMP(a_mid_is_item, clk_i, rst_ni, strobe_o && !last_o, item_valid_o && busy)
  // A refused push reports a full list
  `OLIR_ASSERT_IMP(a_full_count, clk_i, rst_ni, strobe_o && (status_o == STATUS_FULL), entry_count_o == COUNT_W'(CAPACITY))
  // Idle without a command yields no word
  `OLIR_ASSERT_NXT(a_idle_quiet, clk_i, rst_ni, !busy && !start, !strobe_o)

endmodule
